FILE: rtl/euler_rotate_about_point_unit_macros.svh
// Assertion macros for the Euler rotation unit.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef EULER_ROTATE_ABOUT_POINT_UNIT_MACROS_SVH
`define EULER_ROTATE_ABOUT_POINT_UNIT_MACROS_SVH

// cond implies cons in the same cycle
`define ERAP_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// cond implies cons in the next cycle
`define ERAP_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/erap_pkg.sv
// Shared types, constants and tables of the Euler rotation unit.
// No dependencies.
package erap_pkg;

    localparam int CRD_W = 32;
    localparam int TRIG_W = 32;
    localparam int ANG_W = 16;
    localparam int CW = 34;
    localparam int ZW = 34;
    localparam int PROD_W = 65;
    localparam int SUM_W = 67;
    localparam int FRAC_SHIFT = 28;
    localparam int ANGLE_SHIFT = 18;

    localparam logic signed [16:0] FULL_TURN = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [CRD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ANG_W-1:0] angle_t;

    typedef struct packed {
        coord_t [2:0] point;
        coord_t [2:0] pivot;
        trig_t [2:0] cosv;
        trig_t [2:0] sinv;
    } item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic flip;
    } lane_t;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                0: v = 34'sd754974720;
                1: v = 34'sd445687602;
                2: v = 34'sd235489088;
                3: v = 34'sd119537938;
                4: v = 34'sd60000934;
                5: v = 34'sd30029717;
                6: v = 34'sd15018523;
                7: v = 34'sd7509720;
                8: v = 34'sd3754917;
                9: v = 34'sd1877466;
                10: v = 34'sd938734;
                11: v = 34'sd469367;
                12: v = 34'sd234684;
                13: v = 34'sd117342;
                14: v = 34'sd58671;
                15: v = 34'sd29335;
                16: v = 34'sd14668;
                17: v = 34'sd7334;
                18: v = 34'sd3667;
                19: v = 34'sd1833;
                20: v = 34'sd917;
                21: v = 34'sd458;
                22: v = 34'sd229;
                23: v = 34'sd115;
                24: v = 34'sd57;
                25: v = 34'sd29;
                26: v = 34'sd14;
                27: v = 34'sd7;
                28: v = 34'sd4;
                29: v = 34'sd2;
                30: v = 34'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/erap_vertex_if.sv
// Input channel: point, pivot and three angles per beat.
// Depends on erap_pkg.
interface erap_vertex_if
    import erap_pkg::*;
();
    logic valid;
    logic ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t pivot_x;
    coord_t pivot_y;
    coord_t pivot_z;
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;

    modport source (output valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
                    angle_x, angle_y, angle_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
                  angle_x, angle_y, angle_z, output ready);
endinterface

interface erap_result_if
    import erap_pkg::*;
();
    logic valid;
    logic ready;
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;

    modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
    modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

FILE: rtl/euler_rotate_about_point_unit.sv
// Euler rotation of a point about a pivot: x, then y, then z plane.
// Depends on erap_pkg, erap_vertex_if, erap_result_if, erap_cordic, erap_plane.
//
//  channel | dir | payload
//  vertex  | in  | point_x/y/z, pivot_x/y/z, angle_x/y/z
//  result  | out | rotated_x/y/z
//
// One vertex a cycle while the result is not stalled; the pipeline holds the CORDIC
// angle-reduction, micro-rotation and output stages plus two stages per plane.
// Reset clears the valid bits only; no state is kept between vertices.
// A stalled result beat freezes the whole pipeline; nothing is dropped.
`include "euler_rotate_about_point_unit_macros.svh"

module euler_rotate_about_point_unit
    import erap_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    erap_vertex_if.sink    vertex,
    erap_result_if.source  result
);

    logic en;
    item_t in_item;
    angle_t [2:0] angle;
    logic c_vld, p0_vld, p1_vld, p2_vld;
    item_t c_item, p0_item, p1_item, p2_item;

    assign en = !result.valid || result.ready;
    assign vertex.ready = en;

    always_comb
    begin
        in_item = '0;
        in_item.point[0] = vertex.point_x;
        in_item.point[1] = vertex.point_y;
        in_item.point[2] = vertex.point_z;
        in_item.pivot[0] = vertex.pivot_x;
        in_item.pivot[1] = vertex.pivot_y;
        in_item.pivot[2] = vertex.pivot_z;
        angle[0] = vertex.angle_x;
        angle[1] = vertex.angle_y;
        angle[2] = vertex.angle_z;
    end

    erap_cordic #(.N(CORDIC_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vertex.valid), .in_item(in_item), .angle(angle),
        .out_valid(c_vld), .out_item(c_item)
    );

    erap_plane #(.A_IDX(1), .B_IDX(2), .K_IDX(0)) u_plane_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c_vld), .in_item(c_item), .out_valid(p0_vld), .out_item(p0_item)
    );

    erap_plane #(.A_IDX(2), .B_IDX(0), .K_IDX(1)) u_plane_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(p0_vld), .in_item(p0_item), .out_valid(p1_vld), .out_item(p1_item)
    );

    erap_plane #(.A_IDX(0), .B_IDX(1), .K_IDX(2)) u_plane_z (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(p1_vld), .in_item(p1_item), .out_valid(p2_vld), .out_item(p2_item)
    );

    assign result.valid = p2_vld;
    assign result.rotated_x = p2_item.point[0];
    assign result.rotated_y = p2_item.point[1];
    assign result.rotated_z = p2_item.point[2];

    `ERAP_ASSERT_NOW(a_stall_blocks_input, result.valid && !result.ready, !vertex.ready)
    `ERAP_ASSERT_NEXT(a_frozen_valid, !en, result.valid == $past(result.valid))

endmodule

FILE: rtl/erap_cordic.sv
// Angle reduction and pipelined CORDIC for the three angles in lockstep.
// Depends on erap_pkg.
module erap_cordic
    import erap_pkg::*;
#(
    parameter int N = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  item_t          in_item,
    input  angle_t [2:0]   angle,
    output logic           out_valid,
    output item_t          out_item
);

    lane_t lane_reg [0:N][0:2];
    lane_t lane_next [0:N][0:2];
    item_t item_reg [0:N+1];
    logic  vld_reg [0:N+1];
    item_t fin_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [16:0] a;
            logic signed [16:0] r;
            logic flip;
            a = 17'(angle[k]);
            if (a >= HALF_TURN)
                r = a - FULL_TURN;
            else if (a < -HALF_TURN)
                r = a + FULL_TURN;
            else
                r = a;
            flip = 1'b0;
            if (r > QUARTER_TURN)
            begin
                r = r - HALF_TURN;
                flip = 1'b1;
            end
            else if (r < -QUARTER_TURN)
            begin
                r = r + HALF_TURN;
                flip = 1'b1;
            end
            lane_next[0][k].x = CORDIC_GAIN;
            lane_next[0][k].y = '0;
            lane_next[0][k].z = ZW'(r) <<< ANGLE_SHIFT;
            lane_next[0][k].flip = flip;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [CW-1:0] xs;
                logic signed [CW-1:0] ys;
                xs = lane_reg[i][k].x >>> i;
                ys = lane_reg[i][k].y >>> i;
                lane_next[i+1][k].flip = lane_reg[i][k].flip;
                if (!lane_reg[i][k].z[ZW-1])
                begin
                    lane_next[i+1][k].x = lane_reg[i][k].x - ys;
                    lane_next[i+1][k].y = lane_reg[i][k].y + xs;
                    lane_next[i+1][k].z = lane_reg[i][k].z - atan_q24(i);
                end
                else
                begin
                    lane_next[i+1][k].x = lane_reg[i][k].x + ys;
                    lane_next[i+1][k].y = lane_reg[i][k].y - xs;
                    lane_next[i+1][k].z = lane_reg[i][k].z + atan_q24(i);
                end
            end
        end
    end

    always_comb
    begin
        fin_next = item_reg[N];
        for (int k = 0; k < 3; k++)
        begin
            logic signed [CW-1:0] cr;
            logic signed [CW-1:0] sr;
            cr = (lane_reg[N][k].x + CW'(2)) >>> 2;
            sr = (lane_reg[N][k].y + CW'(2)) >>> 2;
            if (lane_reg[N][k].flip)
            begin
                cr = -cr;
                sr = -sr;
            end
            fin_next.cosv[k] = cr[TRIG_W-1:0];
            fin_next.sinv[k] = sr[TRIG_W-1:0];
        end
    end

    for (genvar i = 0; i <= N + 1; i++)
    begin : g_vld
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= in_item;
            for (int i = 1; i <= N; i++)
                item_reg[i] <= item_reg[i-1];
            item_reg[N+1] <= fin_next;
            for (int i = 0; i <= N; i++)
                for (int k = 0; k < 3; k++)
                    lane_reg[i][k] <= lane_next[i][k];
        end
    end

    assign out_valid = vld_reg[N+1];
    assign out_item = item_reg[N+1];

endmodule

FILE: rtl/erap_plane.sv
// One plane rotation about the pivot: products, then round, offset and saturate.
// Depends on erap_pkg.
module erap_plane
    import erap_pkg::*;
#(
    parameter int A_IDX = 1,
    parameter int B_IDX = 2,
    parameter int K_IDX = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = 67'sd134217728;
    localparam logic signed [SUM_W-1:0] SAT_HI = 67'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO = -67'sd2147483648;

    logic signed [32:0] da;
    logic signed [32:0] db;
    logic signed [PROD_W-1:0] p_ac_next, p_bs_next, p_as_next, p_bc_next;
    logic signed [PROD_W-1:0] p_ac_reg, p_bs_reg, p_as_reg, p_bc_reg;
    item_t mid_reg;
    item_t out_next;
    item_t out_reg;
    logic mid_vld_reg;
    logic out_vld_reg;

    function automatic coord_t sat32(input logic signed [SUM_W-1:0] v);
        begin
            if (v > SAT_HI)
                return coord_t'(SAT_HI[CRD_W-1:0]);
            else if (v < SAT_LO)
                return coord_t'(SAT_LO[CRD_W-1:0]);
            else
                return coord_t'(v[CRD_W-1:0]);
        end
    endfunction

    always_comb
    begin
        da = 33'($signed(in_item.point[A_IDX])) - 33'($signed(in_item.pivot[A_IDX]));
        db = 33'($signed(in_item.point[B_IDX])) - 33'($signed(in_item.pivot[B_IDX]));
        p_ac_next = PROD_W'(da) * PROD_W'($signed(in_item.cosv[K_IDX]));
        p_bs_next = PROD_W'(db) * PROD_W'($signed(in_item.sinv[K_IDX]));
        p_as_next = PROD_W'(da) * PROD_W'($signed(in_item.sinv[K_IDX]));
        p_bc_next = PROD_W'(db) * PROD_W'($signed(in_item.cosv[K_IDX]));
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] ta;
        logic signed [SUM_W-1:0] tb;
        ta = (SUM_W'(p_ac_reg) - SUM_W'(p_bs_reg) + ROUND_HALF) >>> FRAC_SHIFT;
        tb = (SUM_W'(p_as_reg) + SUM_W'(p_bc_reg) + ROUND_HALF) >>> FRAC_SHIFT;
        out_next = mid_reg;
        out_next.point[A_IDX] = sat32(SUM_W'($signed(mid_reg.pivot[A_IDX])) + ta);
        out_next.point[B_IDX] = sat32(SUM_W'($signed(mid_reg.pivot[B_IDX])) + tb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            mid_vld_reg <= in_valid;
            out_vld_reg <= mid_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ac_reg <= p_ac_next;
            p_bs_reg <= p_bs_next;
            p_as_reg <= p_as_next;
            p_bc_reg <= p_bc_next;
            mid_reg <= in_item;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item = out_reg;

endmodule
